// File: rtl/core/tpbb_pkg.sv
// tpbb_pkg: shared types and constants of the three-pass box blur.
// No dependencies.
package tpbb_pkg;

	localparam int unsigned MaxWidthDef  = 256;
	localparam int unsigned MaxHeightDef = 256;
	localparam int unsigned MaxRadiusDef = 31;

	localparam int unsigned PixW    = 24;
	localparam int unsigned ChanW   = 8;
	localparam int unsigned IdxW    = 16;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDatW = 9;
	localparam int unsigned DimRegW = 9;
	localparam int unsigned RadRegW = 5;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_RUN   = 2'd1,
		MODE_READ  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_READ  = 2'd0,
		ST_DONE  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_WIDTH  = 3'd0,
		CFG_HEIGHT = 3'd1,
		CFG_RAD0   = 3'd2,
		CFG_RAD1   = 3'd3,
		CFG_RAD2   = 3'd4
	} cfg_idx_t;

	typedef enum logic [9:0] {
		S_IDLE    = 10'b00_0000_0001,
		S_RD_WAIT = 10'b00_0000_0010,
		S_LINE    = 10'b00_0000_0100,
		S_ADDR    = 10'b00_0000_1000,
		S_READ    = 10'b00_0001_0000,
		S_ACC     = 10'b00_0010_0000,
		S_DLOAD   = 10'b00_0100_0000,
		S_DIV     = 10'b00_1000_0000,
		S_WRITE   = 10'b01_0000_0000,
		S_DONE    = 10'b10_0000_0000
	} state_t;

	typedef enum logic [1:0] {
		OP_INIT = 2'd0,
		OP_ADD  = 2'd1,
		OP_SUB  = 2'd2,
		OP_WR   = 2'd3
	} op_t;

endpackage

// File: rtl/core/tpbb_ram.sv
// tpbb_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
module tpbb_ram #(
	parameter int unsigned DATA_W = 24,
	parameter int unsigned DEPTH  = 65536,
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/three_pass_box_blur_rgb.sv
// three_pass_box_blur_rgb: frame store with a sequenced three-pass box blur.
// Uses tpbb_pkg and two tpbb_ram instances (frame and scratch).
//
// channel  direction  handshake              payload
// in       input      in_valid / in_stall    mode, pixel_index, red_in, green_in, blue_in
// out      output     out_valid / out_stall  status, red_out, green_out, blue_out
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Write: frame RAM written on acceptance. Read: registered frame RAM read, then output register.
// Run: per pass, 2*W*H pixels on the single read port and an 8-step divider per channel;
// a line's first pixel sums 2r+1 samples, each further pixel adds one and subtracts one.
// Reset clears control state only; the RAMs are not cleared.
// Output register holds while out_stall; in_stall is high while busy or a held output stalls.
module three_pass_box_blur_rgb #(
	parameter int unsigned MAX_WIDTH  = tpbb_pkg::MaxWidthDef,
	parameter int unsigned MAX_HEIGHT = tpbb_pkg::MaxHeightDef,
	parameter int unsigned MAX_RADIUS = tpbb_pkg::MaxRadiusDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    mode,
	input  logic [tpbb_pkg::IdxW-1:0]     pixel_index,
	input  logic [tpbb_pkg::ChanW-1:0]    red_in,
	input  logic [tpbb_pkg::ChanW-1:0]    green_in,
	input  logic [tpbb_pkg::ChanW-1:0]    blue_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic [tpbb_pkg::ChanW-1:0]    red_out,
	output logic [tpbb_pkg::ChanW-1:0]    green_out,
	output logic [tpbb_pkg::ChanW-1:0]    blue_out,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tpbb_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [tpbb_pkg::CfgDatW-1:0]  cfg_data
);

	localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned MAXDIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int unsigned DIM_W  = $clog2(MAXDIM + 1);
	localparam int unsigned POS_W  = DIM_W + 2;
	localparam int unsigned RAD_W  = $clog2(MAX_RADIUS + 1);
	localparam int unsigned DV_W   = RAD_W + 1;
	localparam int unsigned SUM_W  = $clog2((2 * MAX_RADIUS + 1) * 255 + 1);
	localparam int unsigned PROD_W = 2 * DIM_W + 1;
	localparam int unsigned CW     = tpbb_pkg::ChanW;

	tpbb_pkg::state_t state_q;
	tpbb_pkg::op_t    op_q;

	logic [tpbb_pkg::DimRegW-1:0] width_q, height_q;
	logic [tpbb_pkg::RadRegW-1:0] rad0_q, rad1_q, rad2_q;

	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [CW-1:0]     red_q, green_q, blue_q;

	logic [1:0]        pass_q;
	logic              vert_q;
	logic [DIM_W-1:0]  line_q, i_q;
	logic [ADDR_W-1:0] base_q, addr_q;
	logic signed [POS_W-1:0] mpos_q;
	logic [DV_W-1:0]   cnt_q;
	logic [2:0]        dcnt_q;
	logic [SUM_W-1:0]  sum_q [3];
	logic [DV_W-1:0]   rem_q [3];
	logic [CW-1:0]     lo_q  [3];
	logic [CW-1:0]     quo_q [3];

	logic [DIM_W-1:0]  w_cl, h_cl, len_cur, lines_cur, stride_cur;
	logic [RAD_W-1:0]  r_sat, r_cur;
	logic [tpbb_pkg::RadRegW-1:0] r_sel;
	logic [31:0]       lim32;
	logic [DV_W-1:0]   div_cur;
	logic [2*DIM_W-1:0] count;
	logic              in_acc, idx_ok;
	logic [ADDR_W+tpbb_pkg::IdxW-1:0] idx_wide;
	logic [ADDR_W-1:0] idx_addr;
	logic [DIM_W-1:0]  pos_cl;
	logic [PROD_W-1:0] addr_full;
	logic signed [POS_W-1:0] r_pos, i_pos;

	logic                           f_we, s_we;
	logic [ADDR_W-1:0]              f_waddr, f_raddr;
	logic [tpbb_pkg::PixW-1:0]      f_wdata, f_rdata, s_rdata, src_rdata, blur_px;

	// dimensions and radius for the current phase
	always_comb begin
		if (width_q == '0) w_cl = DIM_W'(1);
		else if (32'(width_q) > MAX_WIDTH) w_cl = DIM_W'(MAX_WIDTH);
		else w_cl = DIM_W'(width_q);
		if (height_q == '0) h_cl = DIM_W'(1);
		else if (32'(height_q) > MAX_HEIGHT) h_cl = DIM_W'(MAX_HEIGHT);
		else h_cl = DIM_W'(height_q);
		len_cur    = vert_q ? h_cl : w_cl;
		lines_cur  = vert_q ? w_cl : h_cl;
		stride_cur = vert_q ? w_cl : DIM_W'(1);
		case (pass_q)
			2'd0:    r_sel = rad0_q;
			2'd1:    r_sel = rad1_q;
			default: r_sel = rad2_q;
		endcase
		if (32'(r_sel) > MAX_RADIUS) r_sat = RAD_W'(MAX_RADIUS);
		else r_sat = RAD_W'(r_sel);
		lim32 = (32'(len_cur) - 32'd1) >> 1;
		r_cur = (32'(r_sat) < lim32) ? r_sat : RAD_W'(lim32);
		div_cur = {r_cur, 1'b1};
		r_pos = $signed(POS_W'(r_cur));
		i_pos = $signed({2'b00, i_q});
	end

	assign count    = w_cl * h_cl;
	assign idx_ok   = 32'(pixel_index) < 32'(count);
	assign idx_wide = {{ADDR_W{1'b0}}, pixel_index};
	assign idx_addr = idx_wide[ADDR_W-1:0];
	assign in_stall = (state_q != tpbb_pkg::S_IDLE) || (out_valid_q && out_stall);
	assign in_acc   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// clamp sample position to the line, then base + pos * stride
	always_comb begin
		if (mpos_q < 0) pos_cl = '0;
		else if (mpos_q >= $signed({2'b00, len_cur})) pos_cl = len_cur - DIM_W'(1);
		else pos_cl = mpos_q[DIM_W-1:0];
		addr_full = PROD_W'(pos_cl) * PROD_W'(stride_cur) + PROD_W'(base_q);
	end

	assign src_rdata = vert_q ? s_rdata : f_rdata;
	assign blur_px   = {quo_q[0], quo_q[1], quo_q[2]};

	assign f_we    = (in_acc && mode == tpbb_pkg::MODE_WRITE && idx_ok) ||
	                 (state_q == tpbb_pkg::S_WRITE && vert_q);
	assign f_waddr = (state_q == tpbb_pkg::S_IDLE) ? idx_addr : addr_q;
	assign f_wdata = (state_q == tpbb_pkg::S_IDLE) ? {red_in, green_in, blue_in} : blur_px;
	assign f_raddr = (state_q == tpbb_pkg::S_IDLE) ? idx_addr : addr_q;
	assign s_we    = (state_q == tpbb_pkg::S_WRITE) && !vert_q;

	tpbb_ram #(.DATA_W(tpbb_pkg::PixW), .DEPTH(DEPTH)) u_frame (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
		.raddr(f_raddr), .rdata(f_rdata)
	);

	tpbb_ram #(.DATA_W(tpbb_pkg::PixW), .DEPTH(DEPTH)) u_scratch (
		.clk(clk), .we(s_we), .waddr(addr_q), .wdata(blur_px),
		.raddr(addr_q), .rdata(s_rdata)
	);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= tpbb_pkg::DimRegW'(256);
			height_q <= tpbb_pkg::DimRegW'(256);
			rad0_q   <= tpbb_pkg::RadRegW'(1);
			rad1_q   <= tpbb_pkg::RadRegW'(1);
			rad2_q   <= tpbb_pkg::RadRegW'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tpbb_pkg::CFG_WIDTH:  width_q  <= cfg_data[tpbb_pkg::DimRegW-1:0];
				tpbb_pkg::CFG_HEIGHT: height_q <= cfg_data[tpbb_pkg::DimRegW-1:0];
				tpbb_pkg::CFG_RAD0:   rad0_q   <= cfg_data[tpbb_pkg::RadRegW-1:0];
				tpbb_pkg::CFG_RAD1:   rad1_q   <= cfg_data[tpbb_pkg::RadRegW-1:0];
				tpbb_pkg::CFG_RAD2:   rad2_q   <= cfg_data[tpbb_pkg::RadRegW-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tpbb_pkg::S_IDLE;
			op_q        <= tpbb_pkg::OP_INIT;
			out_valid_q <= 1'b0;
			pass_q      <= '0;
			vert_q      <= 1'b0;
			line_q      <= '0;
			base_q      <= '0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				tpbb_pkg::S_IDLE: begin
					if (in_acc) begin
						if (mode == tpbb_pkg::MODE_RUN) begin
							pass_q  <= '0;
							vert_q  <= 1'b0;
							line_q  <= '0;
							base_q  <= '0;
							state_q <= tpbb_pkg::S_LINE;
						end else if (mode != tpbb_pkg::MODE_NONE) begin
							if (!idx_ok) begin
								out_valid_q <= 1'b1;
								status_q    <= tpbb_pkg::ST_RANGE;
								red_q       <= '0;
								green_q     <= '0;
								blue_q      <= '0;
							end else if (mode == tpbb_pkg::MODE_READ) begin
								state_q <= tpbb_pkg::S_RD_WAIT;
							end
						end
					end
				end
				tpbb_pkg::S_RD_WAIT: begin
					out_valid_q <= 1'b1;
					status_q    <= tpbb_pkg::ST_READ;
					red_q       <= f_rdata[23:16];
					green_q     <= f_rdata[15:8];
					blue_q      <= f_rdata[7:0];
					state_q     <= tpbb_pkg::S_IDLE;
				end
				tpbb_pkg::S_LINE: begin
					for (int c = 0; c < 3; c++) sum_q[c] <= '0;
					mpos_q  <= -r_pos;
					cnt_q   <= div_cur;
					i_q     <= '0;
					op_q    <= tpbb_pkg::OP_INIT;
					state_q <= tpbb_pkg::S_ADDR;
				end
				tpbb_pkg::S_ADDR: begin
					addr_q  <= addr_full[ADDR_W-1:0];
					state_q <= (op_q == tpbb_pkg::OP_WR) ? tpbb_pkg::S_WRITE : tpbb_pkg::S_READ;
				end
				tpbb_pkg::S_READ: begin
					state_q <= tpbb_pkg::S_ACC;
				end
				tpbb_pkg::S_ACC: begin
					for (int c = 0; c < 3; c++) begin
						if (op_q == tpbb_pkg::OP_SUB)
							sum_q[c] <= sum_q[c] - SUM_W'(src_rdata[23-8*c -: 8]);
						else
							sum_q[c] <= sum_q[c] + SUM_W'(src_rdata[23-8*c -: 8]);
					end
					case (op_q)
						tpbb_pkg::OP_INIT: begin
							mpos_q  <= mpos_q + POS_W'(1);
							cnt_q   <= cnt_q - DV_W'(1);
							state_q <= (cnt_q == DV_W'(1)) ? tpbb_pkg::S_DLOAD : tpbb_pkg::S_ADDR;
						end
						tpbb_pkg::OP_ADD: begin
							mpos_q  <= i_pos - r_pos;
							op_q    <= tpbb_pkg::OP_SUB;
							state_q <= tpbb_pkg::S_ADDR;
						end
						default: begin
							i_q     <= i_q + DIM_W'(1);
							state_q <= tpbb_pkg::S_DLOAD;
						end
					endcase
				end
				tpbb_pkg::S_DLOAD: begin
					for (int c = 0; c < 3; c++) begin
						logic [SUM_W+DV_W:0] dvd;
						dvd = (SUM_W+DV_W+1)'(sum_q[c]) + (SUM_W+DV_W+1)'(r_cur);
						rem_q[c] <= dvd[DV_W+7:8];
						lo_q[c]  <= dvd[7:0];
					end
					dcnt_q  <= '0;
					state_q <= tpbb_pkg::S_DIV;
				end
				tpbb_pkg::S_DIV: begin
					for (int c = 0; c < 3; c++) begin
						logic [DV_W:0] t;
						t = {rem_q[c], lo_q[c][CW-1]};
						lo_q[c] <= lo_q[c] << 1;
						if (t >= {1'b0, div_cur}) begin
							rem_q[c] <= DV_W'(t - {1'b0, div_cur});
							quo_q[c] <= {quo_q[c][CW-2:0], 1'b1};
						end else begin
							rem_q[c] <= t[DV_W-1:0];
							quo_q[c] <= {quo_q[c][CW-2:0], 1'b0};
						end
					end
					dcnt_q <= dcnt_q + 3'd1;
					if (dcnt_q == 3'd7) begin
						mpos_q  <= i_pos;
						op_q    <= tpbb_pkg::OP_WR;
						state_q <= tpbb_pkg::S_ADDR;
					end
				end
				tpbb_pkg::S_WRITE: begin
					if (i_q != len_cur - DIM_W'(1)) begin
						mpos_q  <= i_pos + r_pos + POS_W'(1);
						op_q    <= tpbb_pkg::OP_ADD;
						state_q <= tpbb_pkg::S_ADDR;
					end else if (line_q != lines_cur - DIM_W'(1)) begin
						line_q  <= line_q + DIM_W'(1);
						base_q  <= base_q + (vert_q ? ADDR_W'(1) : ADDR_W'(w_cl));
						state_q <= tpbb_pkg::S_LINE;
					end else begin
						line_q <= '0;
						base_q <= '0;
						if (!vert_q) begin
							vert_q  <= 1'b1;
							state_q <= tpbb_pkg::S_LINE;
						end else begin
							vert_q <= 1'b0;
							if (pass_q == 2'd2) begin
								state_q <= tpbb_pkg::S_DONE;
							end else begin
								pass_q  <= pass_q + 2'd1;
								state_q <= tpbb_pkg::S_LINE;
							end
						end
					end
				end
				tpbb_pkg::S_DONE: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						status_q    <= tpbb_pkg::ST_DONE;
						red_q       <= '0;
						green_q     <= '0;
						blue_q      <= '0;
						state_q     <= tpbb_pkg::S_IDLE;
					end
				end
				default: state_q <= tpbb_pkg::S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign red_out   = red_q;
	assign green_out = green_q;
	assign blue_out  = blue_q;

endmodule

// File: rtl/core/tpbb_checker.sv
// tpbb_checker: port-level assertions for three_pass_box_blur_rgb.
// Uses tpbb_pkg; bound to the top level below.
module tpbb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [1:0] mode,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] status,
	input logic [7:0] red_out,
	input logic [7:0] green_out,
	input logic [7:0] blue_out
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(red_out))
		else $error("output item changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == tpbb_pkg::ST_READ || status == tpbb_pkg::ST_DONE ||
		status == tpbb_pkg::ST_RANGE)
		else $error("bad status code");

	a_zero_chan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != tpbb_pkg::ST_READ |->
		red_out == 8'd0 && green_out == 8'd0 && blue_out == 8'd0)
		else $error("nonzero channels without read data");

	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && mode == tpbb_pkg::MODE_RUN |=> in_stall)
		else $error("item taken right after run start");

endmodule

bind three_pass_box_blur_rgb tpbb_checker u_tpbb_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.mode(mode), .out_valid(out_valid), .out_stall(out_stall), .status(status),
	.red_out(red_out), .green_out(green_out), .blue_out(blue_out)
);
